[design/npm_pkg.sv]
// Package: shared types, widths and codes of the nested pair matcher.
`default_nettype none
package npm_pkg;

    localparam int OFFSET_BITS    = 16;
    localparam int DEPTH_BITS     = 16;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [1:0] STATUS_MATCH    = 2'd0;
    localparam logic [1:0] STATUS_NO_MATCH = 2'd1;
    localparam logic [1:0] STATUS_NO_OPEN  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LEFT   = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RIGHT  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ESCAPE = 2'd2;

    localparam logic [7:0] LEFT_RESET   = 8'd40;
    localparam logic [7:0] RIGHT_RESET  = 8'd41;
    localparam logic [7:0] ESCAPE_RESET = 8'd0;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] match_offset;
    } out_word_t;

    typedef struct packed {
        logic first_byte;
        logic last_byte;
        logic is_left;
        logic is_right;
        logic is_escape;
    } token_t;

endpackage
`default_nettype wire

[design/nested_pair_matcher.sv]
// Top level: balanced delimiter matcher with escape byte.
//
// Input words (s_valid/s_ready) carry one byte of a span with first and last
// marks. The front end compares each byte against the left, right and escape
// registers and pushes a token into a four-entry queue; s_ready is high while
// the queue has room. The back end pops one token per cycle while the output
// register is free or being taken, tracks nesting depth and offset, and loads
// at most one result word per span into the output register (m_valid/m_ready).
// A token is registered in a queue slot and its result word in the output
// register. The block takes one byte per cycle while the receiver keeps up,
// set by the state update of the back end.
// A stalled receiver holds the output register; the back end stops popping
// and the queue fills, after which s_ready falls.
// Reset (aresetn low, synchronous) empties the queue, clears the output and
// the scan state, and restores left '(', right ')' and escape disabled.
// Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the user
// must make them only while the block is idle: the block does not enforce it.
`default_nettype none
module nested_pair_matcher (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [npm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [7:0]                         cfg_data,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire npm_pkg::in_word_t                  s_data,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output npm_pkg::out_word_t                      m_data
);

    npm_pkg::token_t in_token;
    npm_pkg::token_t head_token;
    logic            q_not_full;
    logic            q_not_empty;
    logic            q_pop;

    assign s_ready = q_not_full;

    npm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_word   (s_data),
        .token     (in_token)
    );

    npm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_token (in_token),
        .not_full   (q_not_full),
        .pop        (q_pop),
        .head_token (head_token),
        .not_empty  (q_not_empty)
    );

    npm_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tok_valid (q_not_empty),
        .tok       (head_token),
        .tok_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
`default_nettype wire

[design/npm_front.sv]
// Front end: configuration registers and byte classification into tokens.
`default_nettype none
module npm_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [npm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [7:0]                         cfg_data,
    input  wire npm_pkg::in_word_t                  in_word,
    output npm_pkg::token_t                         token
);

    logic [7:0] left_reg;
    logic [7:0] right_reg;
    logic [7:0] escape_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg   <= npm_pkg::LEFT_RESET;
            right_reg  <= npm_pkg::RIGHT_RESET;
            escape_reg <= npm_pkg::ESCAPE_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                npm_pkg::CFG_LEFT:   left_reg   <= cfg_data;
                npm_pkg::CFG_RIGHT:  right_reg  <= cfg_data;
                npm_pkg::CFG_ESCAPE: escape_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        token.first_byte = in_word.first_byte;
        token.last_byte  = in_word.last_byte;
        token.is_left    = (in_word.data_byte == left_reg);
        token.is_right   = (in_word.data_byte == right_reg);
        token.is_escape  = (escape_reg != 8'd0) && (in_word.data_byte == escape_reg);
    end

endmodule
`default_nettype wire

[design/npm_queue.sv]
// Token queue between front and back ends.
`default_nettype none
module npm_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire npm_pkg::token_t push_token,
    output logic                 not_full,
    input  wire logic            pop,
    output npm_pkg::token_t      head_token,
    output logic                 not_empty
);

    npm_pkg::token_t                     slot_reg [npm_pkg::QUEUE_DEPTH];
    logic [npm_pkg::QUEUE_PTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [npm_pkg::QUEUE_PTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [npm_pkg::QUEUE_CNT_BITS-1:0]  count_reg, count_next;
    logic                                do_push, do_pop;

    assign not_full   = (count_reg != npm_pkg::QUEUE_CNT_BITS'(npm_pkg::QUEUE_DEPTH));
    assign not_empty  = (count_reg != '0);
    assign do_push    = push && not_full;
    assign do_pop     = pop && not_empty;
    assign head_token = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == npm_pkg::QUEUE_PTR_BITS'(npm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == npm_pkg::QUEUE_PTR_BITS'(npm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_token;
        end
    end

endmodule
`default_nettype wire

[design/npm_back.sv]
// Back end: nesting and offset tracking, result register.
`default_nettype none
module npm_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            tok_valid,
    input  wire npm_pkg::token_t tok,
    output logic                 tok_pop,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output npm_pkg::out_word_t   m_data
);

    localparam logic [npm_pkg::OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [npm_pkg::DEPTH_BITS-1:0]  DEPTH_MAX  = '1;

    logic                               scanning_reg, scanning_next;
    logic                               escp_reg, escp_next;
    logic [npm_pkg::DEPTH_BITS-1:0]     depth_reg, depth_next;
    logic [npm_pkg::OFFSET_BITS-1:0]    offset_reg, offset_next;
    logic                               out_valid_reg, out_valid_next;
    npm_pkg::out_word_t                 out_word_reg, out_word_next;
    logic                               emit;
    logic [1:0]                         emit_status;
    logic [npm_pkg::OFFSET_BITS-1:0]    emit_offset;

    assign tok_pop = tok_valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    always_comb begin
        scanning_next = scanning_reg;
        escp_next     = escp_reg;
        depth_next    = depth_reg;
        offset_next   = offset_reg;
        emit          = 1'b0;
        emit_status   = npm_pkg::STATUS_NO_MATCH;
        emit_offset   = '0;
        if (tok.first_byte) begin
            offset_next = '0;
            depth_next  = '0;
            escp_next   = 1'b0;
            if (!tok.is_left) begin
                emit        = 1'b1;
                emit_status = npm_pkg::STATUS_NO_OPEN;
            end else if (tok.last_byte) begin
                emit        = 1'b1;
            end else begin
                scanning_next = 1'b1;
            end
        end else if (scanning_reg) begin
            if (offset_reg != OFFSET_MAX) begin
                offset_next = offset_reg + 1'b1;
            end
            if (escp_reg) begin
                escp_next = 1'b0;
            end else if (tok.is_escape) begin
                escp_next = 1'b1;
            end else if (tok.is_right) begin
                if (depth_reg == '0) begin
                    emit        = 1'b1;
                    emit_status = npm_pkg::STATUS_MATCH;
                    emit_offset = offset_next;
                end else begin
                    depth_next = depth_reg - 1'b1;
                end
            end else if (tok.is_left) begin
                if (depth_reg != DEPTH_MAX) begin
                    depth_next = depth_reg + 1'b1;
                end
            end
            if (tok.last_byte && !emit) begin
                emit        = 1'b1;
                emit_status = npm_pkg::STATUS_NO_MATCH;
            end
        end
        if (emit) begin
            scanning_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (tok_pop && emit) begin
            out_valid_next              = 1'b1;
            out_word_next.status        = emit_status;
            out_word_next.match_offset  = 16'(emit_offset);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scanning_reg  <= 1'b0;
            escp_reg      <= 1'b0;
            depth_reg     <= '0;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (tok_pop) begin
                scanning_reg <= scanning_next;
                escp_reg     <= escp_next;
                depth_reg    <= depth_next;
                offset_reg   <= offset_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_word_reg <= out_word_next;
    end

endmodule
`default_nettype wire
